@@ sv/hilbert_ssb_sideband_select_top_macros.svh @@
// Assertion macros for the sideband selector.
`ifndef HILBERT_SSB_SIDEBAND_SELECT_TOP_MACROS_SVH
`define HILBERT_SSB_SIDEBAND_SELECT_TOP_MACROS_SVH

`define HSSB_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`define HSSB_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ sv/hssb_pkg.sv @@
package hssb_pkg;

   localparam int I_TAPS   = 31;
   localparam int Q_TAPS   = 16;
   localparam int N_COEF   = 8;
   localparam int SAMPLE_W = 16;
   localparam int DIFF_W   = SAMPLE_W + 1;
   localparam int PROD_W   = 32;
   localparam int ACC_W    = 34;
   localparam int SHIFT    = 15;
   localparam int RES_W    = ACC_W - SHIFT + 1;

   typedef logic signed [SAMPLE_W-1:0] sample_type;
   typedef logic signed [DIFF_W-1:0]   diff_type;
   typedef logic signed [PROD_W-1:0]   prod_type;
   typedef logic [1:0]                 mode_type;

   localparam mode_type MODE_IDLE = 2'd0;
   localparam mode_type MODE_USB  = 2'd1;

   localparam sample_type OUT_MAX = 16'sd32767;
   localparam sample_type OUT_MIN = -16'sd32767;

   // Hilbert coefficients for the differences of mirrored even taps, Q15.
   localparam sample_type COEF [N_COEF] = '{
      16'sd97, 16'sd267, 16'sd572, 16'sd1077,
      16'sd1901, 16'sd3330, 16'sd6408, 16'sd20628
   };

endpackage

@@ sv/hilbert_ssb_sideband_select_top.sv @@
// Sideband selector for a phasing SSB demodulator.
// The req channel carries one word per I/Q sample pair (req_sample_i, req_sample_q).
// The rsp channel carries one word per selected sideband sample (rsp_audio_out).
// Both channels use valid/ready; a word moves when valid and ready are both high.
// csr_write_data sets the mode on any cycle with csr_write_enable high:
// 0 drops words and leaves the delay lines alone, 1 adds (upper sideband),
// 2 or 3 subtracts (lower sideband). Change the mode only while the block is idle.
// I runs through a 31-tap Hilbert filter and Q is delayed by 15 samples to match.
// An accepted word passes the product register, then the output register; one
// word can enter every cycle while the output is not stalled. The eight
// multipliers sit in the first stage and the adder tree, arithmetic shift and
// saturation in the second, each ending in a register. When the receiver stalls,
// the output register and the product stage fill and req_ready falls; a waiting
// result never blocks the next word from entering the free product stage.
// Synchronous reset clears both delay lines, the mode and all valid flags.
module hilbert_ssb_sideband_select_top
   import hssb_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  sample_type req_sample_i,
   input  sample_type req_sample_q,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output sample_type rsp_audio_out,
   input  logic       csr_write_enable,
   input  mode_type   csr_write_data
);

   mode_type   mode_ff, mode_in;
   sample_type i_line_ff [I_TAPS];
   sample_type i_line_in [I_TAPS];
   sample_type q_line_ff [Q_TAPS];
   sample_type q_line_in [Q_TAPS];

   logic       p_valid_ff, p_valid_in;
   prod_type   prod_ff [N_COEF];
   prod_type   prod_in [N_COEF];
   sample_type q_ff, q_in;
   logic       sub_ff, sub_in;

   logic       rsp_valid_ff, rsp_valid_in;
   sample_type audio_ff, audio_in;

   logic       accept, load, p_take, out_take;
   diff_type   diff [N_COEF];
   logic signed [ACC_W-1:0] pair_sum [N_COEF/2];
   logic signed [ACC_W-1:0] quad_sum [N_COEF/4];
   logic signed [ACC_W-1:0] acc;
   logic signed [RES_W-1:0] res_base, res;

   assign out_take  = !rsp_valid_ff || rsp_ready;
   assign p_take    = !p_valid_ff || out_take;
   assign req_ready = p_take;
   assign accept    = req_valid && p_take;
   assign load      = accept && (mode_ff != MODE_IDLE);

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_audio_out = audio_ff;

   always_comb begin
      mode_in = csr_write_enable ? csr_write_data : mode_ff;
   end

   always_comb begin
      i_line_in = i_line_ff;
      q_line_in = q_line_ff;
      if (load) begin
         for (int k = 0; k < I_TAPS - 1; k++) begin
            i_line_in[k] = i_line_ff[k + 1];
         end
         i_line_in[I_TAPS - 1] = req_sample_i;
         for (int k = 0; k < Q_TAPS - 1; k++) begin
            q_line_in[k] = q_line_ff[k + 1];
         end
         q_line_in[Q_TAPS - 1] = req_sample_q;
      end
   end

   always_comb begin
      for (int k = 0; k < N_COEF; k++) begin
         diff[k] = DIFF_W'(i_line_in[2 * k]) - DIFF_W'(i_line_in[I_TAPS - 1 - 2 * k]);
         prod_in[k] = PROD_W'(diff[k]) * PROD_W'(COEF[k]);
      end
      q_in       = q_line_in[0];
      sub_in     = (mode_ff != MODE_USB);
      p_valid_in = p_take ? load : p_valid_ff;
   end

   always_comb begin
      for (int j = 0; j < N_COEF / 2; j++) begin
         pair_sum[j] = ACC_W'(prod_ff[2 * j]) + ACC_W'(prod_ff[2 * j + 1]);
      end
      for (int j = 0; j < N_COEF / 4; j++) begin
         quad_sum[j] = pair_sum[2 * j] + pair_sum[2 * j + 1];
      end
      acc = quad_sum[0] + quad_sum[1];
      res_base = RES_W'(acc >>> SHIFT);
      if (sub_ff) begin
         res = res_base - RES_W'(q_ff);
      end else begin
         res = res_base + RES_W'(q_ff);
      end
      if (res > RES_W'(OUT_MAX)) begin
         audio_in = OUT_MAX;
      end else if (res < RES_W'(OUT_MIN)) begin
         audio_in = OUT_MIN;
      end else begin
         audio_in = SAMPLE_W'(res);
      end
      rsp_valid_in = out_take ? p_valid_ff : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_IDLE;
         p_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k < I_TAPS; k++) begin
            i_line_ff[k] <= '0;
         end
         for (int k = 0; k < Q_TAPS; k++) begin
            q_line_ff[k] <= '0;
         end
      end else begin
         mode_ff      <= mode_in;
         p_valid_ff   <= p_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         i_line_ff    <= i_line_in;
         q_line_ff    <= q_line_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         prod_ff <= prod_in;
         q_ff    <= q_in;
         sub_ff  <= sub_in;
      end
      if (out_take && p_valid_ff) begin
         audio_ff <= audio_in;
      end
   end

`include "hilbert_ssb_sideband_select_top_macros.svh"

   `HSSB_ASSERT_NEXT(a_idle_drop, accept && mode_ff == MODE_IDLE, !p_valid_ff, "idle word entered pipe")
   `HSSB_ASSERT_NEXT(a_load, load, p_valid_ff, "accepted word lost before product stage")
   `HSSB_ASSERT_NOW(a_full_block, p_valid_ff && rsp_valid && !rsp_ready, !req_ready, "word taken while full")
   `HSSB_ASSERT_NOW(a_sat_range, rsp_valid, rsp_audio_out != -16'sd32768, "saturation bound broken")

endmodule
